### design/rlms_pkg.sv
// Shared types and constants for the running lower median store.
package rlms_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_DEL_RD,
      S_DEL_WR,
      S_QRY_WAIT,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_LOAD_CNT,
      IDX_LOAD_MID,
      IDX_STEP
   } idx_sel_type;

   typedef enum logic [1:0] {
      RD_MID,
      RD_BELOW,
      RD_ABOVE
   } rd_sel_type;

   typedef struct packed {
      logic        load_val;
      idx_sel_type idx_sel;
      logic        idx_down;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      logic        wr_from_rd;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        cnt_clr;
      logic        res_load;
      status_type  res_status;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic idx_zero;
      logic idx_last;
      logic key_gt;
      logic out_free;
   } stat_type;

endpackage

### design/rlms_if.sv
// Request and response channel interfaces.
interface rlms_req_if;
   logic                 valid;
   logic                 ready;
   rlms_pkg::op_type     opcode;
   logic signed [31:0]   value;
   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface rlms_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   median;
   rlms_pkg::status_type status;
   modport source (output valid, output median, output status, input ready);
   modport sink   (input valid, input median, input status, output ready);
endinterface

### design/running_lower_median_store.sv
// Top level of the running lower median store.
//
//   channel  dir  payload            handshake
//   req      in   opcode, value      valid/ready
//   rsp      out  median, status     valid/ready
//
// Insert walks down from the top, shifting each larger element up one slot until
// the new value's slot is found; delete walks up from the median slot, shifting
// each element above it down; query reads the median slot, and an empty or full
// error and clear need no walk. The walk uses a single memory port, one element
// moved per read and write pair. Reset is synchronous and empties the store. A
// result waiting in the output register does not block new requests; only a
// further result stalls until the output is taken.
module running_lower_median_store #(
   parameter int CAPACITY = 1024
) (
   input logic       clock,
   input logic       reset,
   rlms_req_if.sink  req,
   rlms_rsp_if.source rsp
);

   rlms_pkg::cmd_type  cmd;
   rlms_pkg::stat_type stat;

   rlms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rlms_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req.value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_median (rsp.median),
      .rsp_status (rsp.status)
   );

endmodule

### design/rlms_ctrl.sv
// Sequencer for insert, delete and query transactions.
module rlms_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  rlms_pkg::op_type   req_opcode,
   output logic               req_ready,
   input  rlms_pkg::stat_type stat,
   output rlms_pkg::cmd_type  cmd
);

   rlms_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlms_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlms_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  rlms_pkg::OP_INSERT:
                     state_in = stat.full ? rlms_pkg::S_RESP : rlms_pkg::S_INS_RD;
                  rlms_pkg::OP_QUERY:
                     state_in = stat.empty ? rlms_pkg::S_RESP : rlms_pkg::S_QRY_WAIT;
                  rlms_pkg::OP_DELETE:
                     state_in = stat.empty ? rlms_pkg::S_RESP : rlms_pkg::S_DEL_RD;
                  rlms_pkg::OP_CLEAR:
                     state_in = rlms_pkg::S_IDLE;
               endcase
            end
         end
         rlms_pkg::S_INS_RD:
            state_in = stat.idx_zero ? rlms_pkg::S_IDLE : rlms_pkg::S_INS_CMP;
         rlms_pkg::S_INS_CMP:
            state_in = stat.key_gt ? rlms_pkg::S_INS_RD : rlms_pkg::S_IDLE;
         rlms_pkg::S_DEL_RD:
            state_in = stat.idx_last ? rlms_pkg::S_IDLE : rlms_pkg::S_DEL_WR;
         rlms_pkg::S_DEL_WR:
            state_in = rlms_pkg::S_DEL_RD;
         rlms_pkg::S_QRY_WAIT:
            state_in = rlms_pkg::S_RESP;
         rlms_pkg::S_RESP:
            state_in = stat.out_free ? rlms_pkg::S_IDLE : rlms_pkg::S_RESP;
         default:
            state_in = rlms_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.idx_sel    = rlms_pkg::IDX_HOLD;
      cmd.rd_sel     = rlms_pkg::RD_MID;
      cmd.res_status = rlms_pkg::ST_OK;
      req_ready      = 1'b0;
      unique case (state_ff)
         rlms_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_opcode)
                  rlms_pkg::OP_INSERT: begin
                     if (stat.full) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = rlms_pkg::ST_FULL;
                     end else begin
                        cmd.load_val = 1'b1;
                        cmd.idx_sel  = rlms_pkg::IDX_LOAD_CNT;
                     end
                  end
                  rlms_pkg::OP_QUERY: begin
                     if (stat.empty) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = rlms_pkg::ST_EMPTY;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = rlms_pkg::RD_MID;
                     end
                  end
                  rlms_pkg::OP_DELETE: begin
                     if (stat.empty) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = rlms_pkg::ST_EMPTY;
                     end else begin
                        cmd.idx_sel = rlms_pkg::IDX_LOAD_MID;
                     end
                  end
                  rlms_pkg::OP_CLEAR:
                     cmd.cnt_clr = 1'b1;
               endcase
            end
         end
         rlms_pkg::S_INS_RD: begin
            if (stat.idx_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.cnt_inc = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = rlms_pkg::RD_BELOW;
            end
         end
         rlms_pkg::S_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.key_gt) begin
               // shift the larger element up one slot and keep walking down
               cmd.wr_from_rd = 1'b1;
               cmd.idx_sel    = rlms_pkg::IDX_STEP;
               cmd.idx_down   = 1'b1;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         rlms_pkg::S_DEL_RD: begin
            if (stat.idx_last) begin
               cmd.cnt_dec = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = rlms_pkg::RD_ABOVE;
            end
         end
         rlms_pkg::S_DEL_WR: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_from_rd = 1'b1;
            cmd.idx_sel    = rlms_pkg::IDX_STEP;
         end
         rlms_pkg::S_QRY_WAIT: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = rlms_pkg::ST_OK;
         end
         rlms_pkg::S_RESP:
            cmd.out_load = stat.out_free;
         default: ;
      endcase
   end

endmodule

### design/rlms_dp.sv
// Sorted element memory, count, index and result registers.
module rlms_dp #(
   parameter int CAPACITY = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   req_value,
   input  rlms_pkg::cmd_type    cmd,
   output rlms_pkg::stat_type   stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_median,
   output rlms_pkg::status_type rsp_status
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [31:0]          mem [CAPACITY];
   logic [CW-1:0]        count_ff, count_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [31:0]          val_ff;
   logic [31:0]          rd_data_ff;
   logic [IW-1:0]        rd_addr;
   logic [IW-1:0]        mid;
   logic [CW-1:0]        count_m1;
   logic [31:0]          wr_data;
   logic [31:0]          res_median_ff;
   rlms_pkg::status_type res_status_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_median_ff;
   rlms_pkg::status_type rsp_status_ff;

   assign count_m1 = count_ff - CW'(1);
   assign mid      = IW'(count_m1 >> 1);

   always_comb begin
      unique case (cmd.rd_sel)
         rlms_pkg::RD_BELOW: rd_addr = idx_ff - IW'(1);
         rlms_pkg::RD_ABOVE: rd_addr = idx_ff + IW'(1);
         default:            rd_addr = mid;
      endcase
   end

   assign wr_data = cmd.wr_from_rd ? rd_data_ff : val_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.wr_en) begin
         mem[idx_ff] <= wr_data;
      end
   end

   always_comb begin
      unique case (cmd.idx_sel)
         rlms_pkg::IDX_LOAD_CNT: idx_in = IW'(count_ff);
         rlms_pkg::IDX_LOAD_MID: idx_in = mid;
         rlms_pkg::IDX_STEP:     idx_in = cmd.idx_down ? idx_ff - IW'(1) : idx_ff + IW'(1);
         default:                idx_in = idx_ff;
      endcase
   end

   always_comb begin
      priority if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_m1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_val) begin
         val_ff <= req_value;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_median_ff <= (cmd.res_status == rlms_pkg::ST_OK) ? rd_data_ff : '0;
      end
      if (cmd.out_load) begin
         rsp_median_ff <= res_median_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // flip sign bits so unsigned compare follows signed order
   assign stat.key_gt   = (rd_data_ff ^ 32'h8000_0000) > (val_ff ^ 32'h8000_0000);
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff >= CAP_COUNT);
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.idx_last = (CW'(idx_ff) == count_m1);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### dv/tb_top.sv
// Testbench for the running lower median store, checked against a sorted-queue predictor.
`timescale 1ns / 100ps
module tb_top;

   localparam int CAPACITY = 1024;
   localparam int CYCLE_LIMIT = 40000000;

   typedef struct packed {
      logic signed [31:0]   median;
      rlms_pkg::status_type status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   error_count = 0;
   bit   idle_enable = 1'b1;

   logic signed [31:0] sorted_store[$];
   answer_type         pending_answers[$];

   rlms_req_if req ();
   rlms_rsp_if rsp ();

   running_lower_median_store #(.CAPACITY(CAPACITY)) uut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Apply one transaction to the predictor; queue an answer when one is due.
   function automatic void predict_median_op(rlms_pkg::op_type op, logic signed [31:0] val);
      answer_type a;
      int         pos;
      a.median = '0;
      case (op)
         rlms_pkg::OP_INSERT: begin
            if (sorted_store.size() >= CAPACITY) begin
               a.status = rlms_pkg::ST_FULL;
               pending_answers.push_back(a);
            end else begin
               pos = 0;
               while (pos < sorted_store.size() && sorted_store[pos] <= val) pos++;
               sorted_store.insert(pos, val);
            end
         end
         rlms_pkg::OP_QUERY: begin
            if (sorted_store.size() == 0) begin
               a.status = rlms_pkg::ST_EMPTY;
            end else begin
               a.median = sorted_store[(sorted_store.size() - 1) / 2];
               a.status = rlms_pkg::ST_OK;
            end
            pending_answers.push_back(a);
         end
         rlms_pkg::OP_DELETE: begin
            if (sorted_store.size() == 0) begin
               a.status = rlms_pkg::ST_EMPTY;
               pending_answers.push_back(a);
            end else begin
               sorted_store.delete((sorted_store.size() - 1) / 2);
            end
         end
         default: sorted_store.delete();
      endcase
   endfunction

   // Response sink: random stalls, compare at the rising edge.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result median=%0d status=%0d", $time,
                     rsp.median, rsp.status);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp.median !== want.median) begin
               $display("%0t: median expected %0d actual %0d", $time, want.median,
                        rsp.median);
               error_count++;
            end
            if (rsp.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp.status);
               error_count++;
            end
         end
      end
   end

   // Enter and leave at a falling edge; valid stays high into the next transaction.
   task automatic send_op(rlms_pkg::op_type op, logic signed [31:0] val);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.opcode <= op;
      req.value  <= val;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_median_op(op, val);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 4))
         0: random_value = $signed($urandom_range(0, 15)) - 8;
         1: random_value = 32'sh7FFF_FFF0 + $urandom_range(0, 15);
         2: random_value = 32'sh8000_0000 + $urandom_range(0, 15);
         default: random_value = $urandom;
      endcase
   endfunction

   task automatic test_directed_edges();
      send_op(rlms_pkg::OP_QUERY, 0);
      send_op(rlms_pkg::OP_DELETE, 0);
      send_op(rlms_pkg::OP_INSERT, 32'sh7FFF_FFFF);
      send_op(rlms_pkg::OP_INSERT, 32'sh8000_0000);
      send_op(rlms_pkg::OP_QUERY, 32'shFFFF_FFFF);
      send_op(rlms_pkg::OP_INSERT, -1);
      send_op(rlms_pkg::OP_INSERT, -1);
      send_op(rlms_pkg::OP_QUERY, 0);
      send_op(rlms_pkg::OP_DELETE, 0);
      send_op(rlms_pkg::OP_QUERY, 0);
      send_op(rlms_pkg::OP_INSERT, 0);
      send_op(rlms_pkg::OP_INSERT, 32'sh5555_5555);
      send_op(rlms_pkg::OP_QUERY, 0);
      send_op(rlms_pkg::OP_CLEAR, 0);
      send_op(rlms_pkg::OP_QUERY, 0);
      send_op(rlms_pkg::OP_DELETE, 32'shAAAA_AAAA);
   endtask

   // Fill to capacity with duplicates, try two overflowing inserts, then clear.
   task automatic test_full_store();
      int k;
      for (k = 0; k < CAPACITY; k++) begin
         send_op(rlms_pkg::OP_INSERT, $signed($urandom_range(0, 7)) - 4);
      end
      send_op(rlms_pkg::OP_INSERT, 32'sh1234_5678);
      send_op(rlms_pkg::OP_QUERY, 0);
      send_op(rlms_pkg::OP_INSERT, -5);
      send_op(rlms_pkg::OP_CLEAR, 0);
      send_op(rlms_pkg::OP_QUERY, 0);
   endtask

   task automatic test_random_mix(int count);
      int      k;
      int unsigned r;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 50) send_op(rlms_pkg::OP_INSERT, random_value());
         else if (r < 75) send_op(rlms_pkg::OP_QUERY, random_value());
         else if (r < 97) send_op(rlms_pkg::OP_DELETE, random_value());
         else send_op(rlms_pkg::OP_CLEAR, random_value());
      end
   endtask

   initial begin
      req.valid  = 1'b0;
      req.opcode = rlms_pkg::OP_INSERT;
      req.value  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_edges();
      test_full_store();
      test_random_mix(600);
      idle_enable = 1'b0;
      test_random_mix(250);
      // drop valid after the last transaction
      req.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4 * CAPACITY) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
